@@ rtl/dmac_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dmac_pkg;

   localparam int DMAC_CHANNELS = 4;
   localparam int UNITS_W = 22;

   localparam logic [31:0] CTL_ENABLE = 32'h8000_0000;
   localparam logic [31:0] FULL_COUNT_MASK = 32'h001f_ffff;
   localparam logic [31:0] SHORT_COUNT_MASK = 32'h0000_ffff;
   localparam int CTL_ENABLE_BIT = 31;
   localparam int CTL_IRQ_BIT = 30;
   localparam int CTL_WORDS_BIT = 26;
   localparam int CTL_REPEAT_BIT = 25;

   localparam logic [1:0] REG_SOURCE = 2'd0;
   localparam logic [1:0] REG_DESTINATION = 2'd1;
   localparam logic [1:0] REG_CONTROL = 2'd2;

   localparam logic [1:0] AMODE_DECREMENT = 2'd1;
   localparam logic [1:0] AMODE_FIXED = 2'd2;
   localparam logic [1:0] AMODE_RELOAD = 2'd3;

   typedef enum logic [2:0] {
      MODE_WR_SRC = 3'd0,
      MODE_WR_DST = 3'd1,
      MODE_WR_CTL = 3'd2,
      MODE_READ   = 3'd3,
      MODE_EVENT  = 3'd4,
      MODE_STEP   = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      TIM_IMMEDIATE   = 2'd0,
      TIM_VBLANK      = 2'd1,
      TIM_HBLANK      = 2'd2,
      TIM_UNSUPPORTED = 2'd3
   } timing_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [1:0]  channel;
      logic [1:0]  which_register;
      logic [31:0] write_value;
      logic        moment;
   } item_type;

   typedef struct packed {
      logic        copy_valid;
      logic [31:0] copy_source;
      logic [31:0] copy_destination;
      logic        copy_words;
      logic [1:0]  copy_channel;
      logic        last_unit;
      logic [3:0]  irq_request;
      logic [31:0] read_data;
      logic [31:0] unsupported_count;
   } result_type;

   function automatic timing_type timing_of(input logic [31:0] ctl, input logic main_side);
      logic [2:0] field;
      timing_type t;
      field = main_side ? ctl[29:27] : {1'b0, ctl[29:28]};
      if (field == 3'd0) begin
         t = TIM_IMMEDIATE;
      end else if (field == 3'd1) begin
         t = TIM_VBLANK;
      end else if (field == 3'd2 && main_side) begin
         t = TIM_HBLANK;
      end else begin
         t = TIM_UNSUPPORTED;
      end
      return t;
   endfunction

   function automatic logic [UNITS_W-1:0] units_of(input logic [31:0] ctl,
                                                   input logic main_side);
      logic [31:0] mask;
      logic [31:0] n;
      mask = main_side ? FULL_COUNT_MASK : SHORT_COUNT_MASK;
      n = ctl & mask;
      if (n == 32'd0) begin
         n = mask + 32'd1;
      end
      return n[UNITS_W-1:0];
   endfunction

   function automatic logic [31:0] addr_step(input logic [1:0] amode, input logic words);
      logic [31:0] unit;
      logic [31:0] step;
      unit = words ? 32'd4 : 32'd2;
      if (amode == AMODE_DECREMENT) begin
         step = 32'd0 - unit;
      end else if (amode == AMODE_FIXED) begin
         step = 32'd0;
      end else begin
         step = unit;
      end
      return step;
   endfunction

endpackage

`default_nettype wire

@@ rtl/dmac_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dmac_engine
   import dmac_pkg::*;
#(
   parameter int CHANNELS = DMAC_CHANNELS
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       fire,
   input  wire item_type   item,
   input  wire logic       main_side,
   output result_type      result
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [31:0] src_regs_ff [CHANNELS];
   logic [31:0] src_regs_in [CHANNELS];
   logic [31:0] dst_regs_ff [CHANNELS];
   logic [31:0] dst_regs_in [CHANNELS];
   logic [31:0] ctl_regs_ff [CHANNELS];
   logic [31:0] ctl_regs_in [CHANNELS];
   logic [31:0] src_cur_ff [CHANNELS];
   logic [31:0] src_cur_in [CHANNELS];
   logic [31:0] dst_cur_ff [CHANNELS];
   logic [31:0] dst_cur_in [CHANNELS];
   logic [CHANNELS-1:0] pending_ff;
   logic [CHANNELS-1:0] pending_in;
   logic                active_valid_ff;
   logic                active_valid_in;
   logic [CH_W-1:0]     active_ch_ff;
   logic [CH_W-1:0]     active_ch_in;
   logic [UNITS_W-1:0]  units_left_ff;
   logic [UNITS_W-1:0]  units_left_in;
   logic [31:0]         unsup_ff;
   logic [31:0]         unsup_in;

   logic [7:0]          chan_wide;
   logic                ch_ok;
   logic [CH_W-1:0]     req_idx;
   logic                pick_valid;
   logic [CH_W-1:0]     pick_idx;
   logic [CH_W-1:0]     step_idx;
   logic                step_go;
   logic [CH_W-1:0]     sel_idx;
   logic [31:0]         sel_src;
   logic [31:0]         sel_dst;
   logic [31:0]         sel_ctl;
   logic [31:0]         sel_scur;
   logic [31:0]         sel_dcur;
   logic [UNITS_W-1:0]  units;
   logic [UNITS_W-1:0]  units_next;
   logic [7:0]          irq_full;
   timing_type          want;
   timing_type          wr_timing;

   always_comb begin
      chan_wide = 8'(item.channel);
      ch_ok = chan_wide < 8'(CHANNELS);
      req_idx = chan_wide[CH_W-1:0];

      pick_valid = 1'b0;
      pick_idx = '0;
      for (int c = CHANNELS - 1; c >= 0; c--) begin
         if (pending_ff[c]) begin
            pick_valid = 1'b1;
            pick_idx = CH_W'(c);
         end
      end
      step_idx = active_valid_ff ? active_ch_ff : pick_idx;
      step_go = active_valid_ff || pick_valid;
      sel_idx = (item.mode == MODE_STEP) ? step_idx : req_idx;

      sel_src = src_regs_ff[sel_idx];
      sel_dst = dst_regs_ff[sel_idx];
      sel_ctl = ctl_regs_ff[sel_idx];
      sel_scur = src_cur_ff[sel_idx];
      sel_dcur = dst_cur_ff[sel_idx];

      src_regs_in = src_regs_ff;
      dst_regs_in = dst_regs_ff;
      ctl_regs_in = ctl_regs_ff;
      src_cur_in = src_cur_ff;
      dst_cur_in = dst_cur_ff;
      pending_in = pending_ff;
      active_valid_in = active_valid_ff;
      active_ch_in = active_ch_ff;
      units_left_in = units_left_ff;
      unsup_in = unsup_ff;
      result = '0;

      units = active_valid_ff ? units_left_ff : units_of(sel_ctl, main_side);
      units_next = (units != '0) ? units - UNITS_W'(1) : '0;
      irq_full = 8'(1) << step_idx;
      want = item.moment ? TIM_HBLANK : TIM_VBLANK;
      wr_timing = timing_of(item.write_value, main_side);

      unique case (item.mode)
         MODE_WR_SRC: begin
            if (ch_ok) begin
               src_regs_in[req_idx] = item.write_value;
            end
         end
         MODE_WR_DST: begin
            if (ch_ok) begin
               dst_regs_in[req_idx] = item.write_value;
            end
         end
         MODE_WR_CTL: begin
            if (ch_ok) begin
               ctl_regs_in[req_idx] = item.write_value;
               // rising edge of enable latches the cursors
               if (!sel_ctl[CTL_ENABLE_BIT] && item.write_value[CTL_ENABLE_BIT]) begin
                  src_cur_in[req_idx] = sel_src;
                  dst_cur_in[req_idx] = sel_dst;
                  if (wr_timing == TIM_UNSUPPORTED) begin
                     unsup_in = unsup_ff + 32'd1;
                  end
                  if (wr_timing == TIM_IMMEDIATE) begin
                     pending_in[req_idx] = 1'b1;
                  end
               end
            end
         end
         MODE_READ: begin
            if (ch_ok) begin
               if (item.which_register == REG_SOURCE) begin
                  result.read_data = sel_src;
               end else if (item.which_register == REG_DESTINATION) begin
                  result.read_data = sel_dst;
               end else if (item.which_register == REG_CONTROL) begin
                  result.read_data = sel_ctl;
               end
            end
         end
         MODE_EVENT: begin
            for (int c = 0; c < CHANNELS; c++) begin
               if (ctl_regs_ff[c][CTL_ENABLE_BIT] &&
                   timing_of(ctl_regs_ff[c], main_side) == want) begin
                  pending_in[c] = 1'b1;
               end
            end
         end
         MODE_STEP: begin
            if (step_go) begin
               if (!active_valid_ff) begin
                  pending_in[pick_idx] = 1'b0;
               end
               result.copy_valid = 1'b1;
               result.copy_source = sel_scur;
               result.copy_destination = sel_dcur;
               result.copy_words = sel_ctl[CTL_WORDS_BIT];
               result.copy_channel = 2'(step_idx);
               src_cur_in[step_idx] = sel_scur
                  + addr_step(sel_ctl[24:23], sel_ctl[CTL_WORDS_BIT]);
               dst_cur_in[step_idx] = sel_dcur
                  + addr_step(sel_ctl[22:21], sel_ctl[CTL_WORDS_BIT]);
               units_left_in = units_next;
               active_valid_in = 1'b1;
               active_ch_in = step_idx;
               if (units_next == '0) begin
                  result.last_unit = 1'b1;
                  if (sel_ctl[CTL_IRQ_BIT]) begin
                     result.irq_request = irq_full[3:0];
                  end
                  if (sel_ctl[CTL_REPEAT_BIT] &&
                      timing_of(sel_ctl, main_side) != TIM_IMMEDIATE) begin
                     if (sel_ctl[22:21] == AMODE_RELOAD) begin
                        dst_cur_in[step_idx] = sel_dst;
                     end
                  end else begin
                     ctl_regs_in[step_idx] = sel_ctl & ~CTL_ENABLE;
                  end
                  active_valid_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase

      result.unsupported_count = unsup_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            src_regs_ff[c] <= '0;
            dst_regs_ff[c] <= '0;
            ctl_regs_ff[c] <= '0;
            src_cur_ff[c] <= '0;
            dst_cur_ff[c] <= '0;
         end
         pending_ff <= '0;
         active_valid_ff <= 1'b0;
         active_ch_ff <= '0;
         units_left_ff <= '0;
         unsup_ff <= '0;
      end else if (fire) begin
         src_regs_ff <= src_regs_in;
         dst_regs_ff <= dst_regs_in;
         ctl_regs_ff <= ctl_regs_in;
         src_cur_ff <= src_cur_in;
         dst_cur_ff <= dst_cur_in;
         pending_ff <= pending_in;
         active_valid_ff <= active_valid_in;
         active_ch_ff <= active_ch_in;
         units_left_ff <= units_left_in;
         unsup_ff <= unsup_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/dma_channel_controller.sv @@
// DMA channel controller with CHANNELS channels (default 4).
// Request channel (req_*): one command per transfer, either a register write
// (source, destination, control), a register read, a blank event or a step.
// Response channel (rsp_*): exactly one response per request, in order. A step
// response carries at most one copy (addresses, unit size, channel, last unit
// and interrupt bits); a read response carries read_data.
// Config channel (csr_*): selects main or secondary side; write it only while
// no request is in flight. csr_ready is always high.
// Flow: a taken request is held in the input register, processed by the engine
// when it advances, and its response is held in the output register from then on.
// Throughput: one request per cycle while the receiver takes the responses, set by
// the single register stage that holds the input and the output register that
// holds the response. Reset: all channel registers, cursors, pending bits and the
// unsupported counter clear, no channel is active, main side is selected.
// When the receiver stalls, the response holds and the input stage fills;
// req_ready then drops until the response is taken.
`timescale 1ns / 1ps
`default_nettype none

module dma_channel_controller
   import dmac_pkg::*;
#(
   parameter int CHANNELS = DMAC_CHANNELS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_mode,
   input  wire logic [1:0]  req_channel,
   input  wire logic [1:0]  req_which_register,
   input  wire logic [31:0] req_write_value,
   input  wire logic        req_moment,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_copy_valid,
   output logic [31:0]      rsp_copy_source,
   output logic [31:0]      rsp_copy_destination,
   output logic             rsp_copy_words,
   output logic [1:0]       rsp_copy_channel,
   output logic             rsp_last_unit,
   output logic [3:0]       rsp_irq_request,
   output logic [31:0]      rsp_read_data,
   output logic [31:0]      rsp_unsupported_count,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_main_side
);

   logic       main_side_ff;
   item_type   item_ff;
   logic       item_valid_ff;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   result_type result;
   logic       adv;

   assign adv = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || adv;
   assign csr_ready = 1'b1;

   dmac_engine #(
      .CHANNELS(CHANNELS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .fire      (adv),
      .item      (item_ff),
      .main_side (main_side_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         main_side_ff <= 1'b1;
         item_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            main_side_ff <= csr_main_side;
         end
         if (req_valid && req_ready) begin
            item_valid_ff <= 1'b1;
         end else if (adv) begin
            item_valid_ff <= 1'b0;
         end
         if (adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.mode <= req_mode;
         item_ff.channel <= req_channel;
         item_ff.which_register <= req_which_register;
         item_ff.write_value <= req_write_value;
         item_ff.moment <= req_moment;
      end
      if (adv) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_copy_valid = rsp_ff.copy_valid;
   assign rsp_copy_source = rsp_ff.copy_source;
   assign rsp_copy_destination = rsp_ff.copy_destination;
   assign rsp_copy_words = rsp_ff.copy_words;
   assign rsp_copy_channel = rsp_ff.copy_channel;
   assign rsp_last_unit = rsp_ff.last_unit;
   assign rsp_irq_request = rsp_ff.irq_request;
   assign rsp_read_data = rsp_ff.read_data;
   assign rsp_unsupported_count = rsp_ff.unsupported_count;

   // a processed request always lands in the response register
   assert property (@(posedge clock) disable iff (reset) adv |=> rsp_valid)
      else $error("processed request lost");

   // interrupts only come with the last unit of a copy
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_irq_request != 4'd0) |-> rsp_copy_valid && rsp_last_unit)
      else $error("interrupt without last unit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(rsp_irq_request))
      else $error("more than one interrupt per transfer");

   // a copy response never carries read data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_copy_valid |-> rsp_read_data == 32'd0)
      else $error("copy with read data");

endmodule

`default_nettype wire

@@ verif/dma_channel_controller_test.sv @@
`timescale 1ns / 1ps

module dma_channel_controller_test;
   import dmac_pkg::*;

   localparam int NCH = DMAC_CHANNELS;
   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic [2:0] MODE_SPARE_LO = 3'd6;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;
   localparam logic [1:0] REG_NONE = 2'd3;
   localparam logic [1:0] AMODE_INCREMENT = 2'd0;
   localparam logic [2:0] TIMING_IMMED = 3'd0;
   localparam logic [2:0] TIMING_VBL = 3'd1;
   localparam logic [2:0] TIMING_HBL = 3'd2;
   localparam logic [2:0] TIMING_BAD = 3'd7;
   localparam logic MOMENT_VBLANK = 1'b0;
   localparam logic MOMENT_HBLANK = 1'b1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_mode = '0;
   logic [1:0]  req_channel = '0;
   logic [1:0]  req_which_register = '0;
   logic [31:0] req_write_value = '0;
   logic        req_moment = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_copy_valid;
   logic [31:0] rsp_copy_source;
   logic [31:0] rsp_copy_destination;
   logic        rsp_copy_words;
   logic [1:0]  rsp_copy_channel;
   logic        rsp_last_unit;
   logic [3:0]  rsp_irq_request;
   logic [31:0] rsp_read_data;
   logic [31:0] rsp_unsupported_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_main_side = 1'b1;

   dma_channel_controller DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_mode),
      .req_channel          (req_channel),
      .req_which_register   (req_which_register),
      .req_write_value      (req_write_value),
      .req_moment           (req_moment),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_copy_valid       (rsp_copy_valid),
      .rsp_copy_source      (rsp_copy_source),
      .rsp_copy_destination (rsp_copy_destination),
      .rsp_copy_words       (rsp_copy_words),
      .rsp_copy_channel     (rsp_copy_channel),
      .rsp_last_unit        (rsp_last_unit),
      .rsp_irq_request      (rsp_irq_request),
      .rsp_read_data        (rsp_read_data),
      .rsp_unsupported_count(rsp_unsupported_count),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_main_side        (csr_main_side)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow copy of the controller state
   logic                main_side_sel = 1'b1;
   logic [31:0]         src_word [NCH] = '{default: '0};
   logic [31:0]         dst_word [NCH] = '{default: '0};
   logic [31:0]         ctl_word [NCH] = '{default: '0};
   logic [31:0]         src_ptr [NCH] = '{default: '0};
   logic [31:0]         dst_ptr [NCH] = '{default: '0};
   logic [NCH-1:0]      pending_mask = '0;
   int                  busy_channel = NCH;
   logic [UNITS_W-1:0]  units_remaining = '0;
   logic [31:0]         unsupported_arms = '0;

   typedef struct {
      item_type   cmd;
      bit         fixed;
      result_type want;
   } script_row_type;

   script_row_type script [$];
   result_type outcome_fifo [$];
   result_type rsp_seen;
   result_type rsp_want;
   int         error_count = 0;
   int         idle_cycles = 0;
   int         sent_count = 0;
   int         send_idle_pct = 0;
   int         stall_pct = 0;

   function automatic timing_type decode_timing(input logic [31:0] c);
      logic [2:0] f;
      f = main_side_sel ? c[29:27] : {1'b0, c[29:28]};
      case (f)
         TIMING_IMMED: return TIM_IMMEDIATE;
         TIMING_VBL: return TIM_VBLANK;
         TIMING_HBL: return main_side_sel ? TIM_HBLANK : TIM_UNSUPPORTED;
         default: return TIM_UNSUPPORTED;
      endcase
   endfunction

   function automatic logic [UNITS_W-1:0] unit_count(input logic [31:0] c);
      logic [UNITS_W-1:0] n;
      n = main_side_sel ? {1'b0, c[20:0]} : {6'd0, c[15:0]};
      if (n == '0) begin
         n = main_side_sel ? 22'h20_0000 : 22'h01_0000;
      end
      return n;
   endfunction

   function automatic logic [31:0] addr_delta(input logic [1:0] am, input logic w);
      logic [31:0] u;
      u = w ? 32'd4 : 32'd2;
      case (am)
         AMODE_DECREMENT: return 32'd0 - u;
         AMODE_FIXED: return 32'd0;
         default: return u;
      endcase
   endfunction

   function automatic void apply_control(input int ch, input logic [31:0] v);
      logic       was_on;
      timing_type t;
      was_on = ctl_word[ch][CTL_ENABLE_BIT];
      ctl_word[ch] = v;
      if (!was_on && v[CTL_ENABLE_BIT]) begin
         src_ptr[ch] = src_word[ch];
         dst_ptr[ch] = dst_word[ch];
         t = decode_timing(v);
         if (t == TIM_UNSUPPORTED) begin
            unsupported_arms = unsupported_arms + 32'd1;
         end
         if (t == TIM_IMMEDIATE) begin
            pending_mask[ch] = 1'b1;
         end
      end
   endfunction

   function automatic result_type copy_step();
      result_type r;
      logic [31:0] c;
      logic        w;
      logic [1:0]  dm;
      logic [1:0]  sm;
      int          ch;
      int          i;
      r = '0;
      if (busy_channel >= NCH) begin
         ch = NCH;
         for (i = NCH - 1; i >= 0; i--) begin
            if (pending_mask[i]) ch = i;
         end
         if (ch == NCH) return r;
         pending_mask[ch] = 1'b0;
         busy_channel = ch;
         units_remaining = unit_count(ctl_word[ch]);
      end
      ch = busy_channel;
      c = ctl_word[ch];
      w = c[CTL_WORDS_BIT];
      dm = c[22:21];
      sm = c[24:23];
      r.copy_valid = 1'b1;
      r.copy_source = src_ptr[ch];
      r.copy_destination = dst_ptr[ch];
      r.copy_words = w;
      r.copy_channel = 2'(ch);
      src_ptr[ch] = src_ptr[ch] + addr_delta(sm, w);
      dst_ptr[ch] = dst_ptr[ch] + addr_delta(dm, w);
      if (units_remaining != '0) units_remaining = units_remaining - UNITS_W'(1);
      if (units_remaining == '0) begin
         r.last_unit = 1'b1;
         if (c[CTL_IRQ_BIT]) r.irq_request[ch] = 1'b1;
         if (c[CTL_REPEAT_BIT] && decode_timing(c) != TIM_IMMEDIATE) begin
            if (dm == AMODE_RELOAD) dst_ptr[ch] = dst_word[ch];
         end else begin
            ctl_word[ch][CTL_ENABLE_BIT] = 1'b0;
         end
         busy_channel = NCH;
      end
      return r;
   endfunction

   function automatic result_type dma_outcome(input item_type it);
      result_type r;
      timing_type hit;
      int         ch;
      int         i;
      r = '0;
      ch = int'(it.channel);
      case (it.mode)
         MODE_WR_SRC: src_word[ch] = it.write_value;
         MODE_WR_DST: dst_word[ch] = it.write_value;
         MODE_WR_CTL: apply_control(ch, it.write_value);
         MODE_READ: begin
            case (it.which_register)
               REG_SOURCE: r.read_data = src_word[ch];
               REG_DESTINATION: r.read_data = dst_word[ch];
               REG_CONTROL: r.read_data = ctl_word[ch];
               default: r.read_data = '0;
            endcase
         end
         MODE_EVENT: begin
            hit = it.moment ? TIM_HBLANK : TIM_VBLANK;
            for (i = 0; i < NCH; i++) begin
               if (ctl_word[i][CTL_ENABLE_BIT] && decode_timing(ctl_word[i]) == hit) begin
                  pending_mask[i] = 1'b1;
               end
            end
         end
         MODE_STEP: r = copy_step();
         default: r = '0;
      endcase
      r.unsupported_count = unsupported_arms;
      return r;
   endfunction

   function automatic logic [31:0] ctl_value(input logic en, input logic irq,
                                             input logic words, input logic rpt,
                                             input logic [2:0] tim, input logic [1:0] sm,
                                             input logic [1:0] dm, input logic [20:0] cnt);
      return {en, irq, tim, words, rpt, sm, dm, cnt};
   endfunction

   function automatic item_type make_item(input logic [2:0] mode, input logic [1:0] ch,
                                          input logic [1:0] sel, input logic [31:0] val,
                                          input logic mom);
      item_type it;
      it.mode = mode;
      it.channel = ch;
      it.which_register = sel;
      it.write_value = val;
      it.moment = mom;
      return it;
   endfunction

   function automatic void put(input logic [2:0] mode, input logic [1:0] ch,
                               input logic [1:0] sel, input logic [31:0] val,
                               input logic mom);
      script.push_back('{cmd: make_item(mode, ch, sel, val, mom), fixed: 1'b0, want: '0});
   endfunction

   function automatic void put_known(input logic [2:0] mode, input logic [1:0] ch,
                                     input logic [1:0] sel, input logic [31:0] val,
                                     input logic mom, input logic [31:0] rd,
                                     input logic [31:0] unsup);
      result_type w;
      w = '0;
      w.read_data = rd;
      w.unsupported_count = unsup;
      script.push_back('{cmd: make_item(mode, ch, sel, val, mom), fixed: 1'b1, want: w});
   endfunction

   task automatic send_request(input item_type it, input bit fixed, input result_type want);
      result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= it.mode;
      req_channel <= it.channel;
      req_which_register <= it.which_register;
      req_write_value <= it.write_value;
      req_moment <= it.moment;
      do @(posedge clock); while (!req_ready);
      r = dma_outcome(it);
      outcome_fifo.push_back(fixed ? want : r);
   endtask

   // keep control words with a live count small so transfers stay short
   task automatic issue(input logic [2:0] mode, input logic [1:0] ch, input logic [1:0] sel,
                        input logic [31:0] val, input logic mom);
      logic [31:0] v;
      v = val;
      if (mode == MODE_WR_CTL && (v[CTL_ENABLE_BIT] || pending_mask[ch])) begin
         v[20:0] = 21'($urandom_range(1, 7));
      end
      send_request(make_item(mode, ch, sel, v, mom), 1'b0, '0);
      if (mode <= MODE_STEP) sent_count++;
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (outcome_fifo.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_side(input logic side);
      wait_quiet();
      csr_valid <= 1'b1;
      csr_main_side <= side;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      main_side_sel = side;
   endtask

   task automatic run_traffic(input int target);
      int         start;
      int         n;
      int         t;
      logic [1:0] ch;
      logic [2:0] tim;
      start = sent_count;
      while (sent_count - start < target) begin
         if ($urandom_range(9) < 7) begin
            ch = 2'($urandom_range(3));
            t = $urandom_range(9);
            tim = t < 3 ? TIMING_IMMED : t < 6 ? TIMING_VBL : t < 8 ? TIMING_HBL :
                  3'($urandom_range(3, 7));
            issue(MODE_WR_SRC, ch, 2'($urandom_range(3)), $urandom, 1'($urandom_range(1)));
            issue(MODE_WR_DST, ch, 2'($urandom_range(3)), $urandom, 1'($urandom_range(1)));
            issue(MODE_WR_CTL, ch, REG_CONTROL, $urandom & ~CTL_ENABLE, MOMENT_VBLANK);
            issue(MODE_WR_CTL, ch, REG_CONTROL,
                  ctl_value(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)),
                            1'($urandom_range(1)), tim, 2'($urandom_range(3)),
                            2'($urandom_range(3)), 21'd1),
                  MOMENT_VBLANK);
            n = $urandom_range(2);
            repeat (n) issue(MODE_EVENT, 2'($urandom_range(3)), 2'($urandom_range(3)),
                             $urandom, 1'($urandom_range(1)));
            n = $urandom_range(1, 10);
            repeat (n) issue(MODE_STEP, 2'($urandom_range(3)), 2'($urandom_range(3)),
                             $urandom, 1'($urandom_range(1)));
            if ($urandom_range(3) == 0) begin
               issue(MODE_READ, 2'($urandom_range(3)), 2'($urandom_range(3)), $urandom,
                     1'($urandom_range(1)));
            end
         end else begin
            n = $urandom_range(1, 3);
            repeat (n) issue(3'($urandom_range(7)), 2'($urandom_range(3)),
                             2'($urandom_range(3)), $urandom, 1'($urandom_range(1)));
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen.copy_valid = rsp_copy_valid;
         rsp_seen.copy_source = rsp_copy_source;
         rsp_seen.copy_destination = rsp_copy_destination;
         rsp_seen.copy_words = rsp_copy_words;
         rsp_seen.copy_channel = rsp_copy_channel;
         rsp_seen.last_unit = rsp_last_unit;
         rsp_seen.irq_request = rsp_irq_request;
         rsp_seen.read_data = rsp_read_data;
         rsp_seen.unsupported_count = rsp_unsupported_count;
         if (outcome_fifo.size() == 0) begin
            error_count++;
            if (error_count <= 10) $display("unexpected response at %0t", $time);
         end else begin
            rsp_want = outcome_fifo.pop_front();
            if (rsp_seen !== rsp_want) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("mismatch at %0t", $time);
                  $display("  exp cv=%b src=%h dst=%h w=%b ch=%0d last=%b irq=%h rd=%h uns=%h",
                           rsp_want.copy_valid, rsp_want.copy_source,
                           rsp_want.copy_destination, rsp_want.copy_words,
                           rsp_want.copy_channel, rsp_want.last_unit,
                           rsp_want.irq_request, rsp_want.read_data,
                           rsp_want.unsupported_count);
                  $display("  got cv=%b src=%h dst=%h w=%b ch=%0d last=%b irq=%h rd=%h uns=%h",
                           rsp_seen.copy_valid, rsp_seen.copy_source,
                           rsp_seen.copy_destination, rsp_seen.copy_words,
                           rsp_seen.copy_channel, rsp_seen.last_unit,
                           rsp_seen.irq_request, rsp_seen.read_data,
                           rsp_seen.unsupported_count);
               end
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= stall_pct);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      // directed rows
      put_known(MODE_READ, 2'd0, REG_SOURCE, 32'h0, MOMENT_VBLANK, 32'h0, 32'h0);
      put_known(MODE_STEP, 2'd3, REG_NONE, 32'hffff_ffff, MOMENT_HBLANK, 32'h0, 32'h0);
      put_known(MODE_SPARE_LO, 2'd1, REG_DESTINATION, 32'h1234_5678, MOMENT_VBLANK,
                32'h0, 32'h0);
      put_known(MODE_SPARE_HI, 2'd3, REG_NONE, 32'hffff_ffff, MOMENT_HBLANK, 32'h0, 32'h0);
      put(MODE_WR_SRC, 2'd0, REG_SOURCE, 32'hffff_fffe, MOMENT_VBLANK);
      put_known(MODE_READ, 2'd0, REG_SOURCE, 32'h0, MOMENT_VBLANK, 32'hffff_fffe, 32'h0);
      put_known(MODE_READ, 2'd0, REG_NONE, 32'h0, MOMENT_VBLANK, 32'h0, 32'h0);
      put(MODE_WR_DST, 2'd0, REG_SOURCE, 32'h0000_0002, MOMENT_VBLANK);
      put(MODE_WR_CTL, 2'd0, REG_CONTROL,
          ctl_value(1'b1, 1'b1, 1'b1, 1'b0, TIMING_IMMED, AMODE_INCREMENT,
                    AMODE_DECREMENT, 21'd2), MOMENT_VBLANK);
      put(MODE_STEP, 2'd0, REG_SOURCE, 32'h0, MOMENT_VBLANK);
      put(MODE_STEP, 2'd0, REG_SOURCE, 32'h0, MOMENT_VBLANK);
      // unsupported timing bumps the counter but never makes the channel pending
      put_known(MODE_WR_CTL, 2'd3, REG_CONTROL,
                ctl_value(1'b1, 1'b1, 1'b0, 1'b0, TIMING_BAD, AMODE_FIXED, AMODE_FIXED,
                          21'd1), MOMENT_VBLANK, 32'h0, 32'h1);
      put(MODE_WR_SRC, 2'd1, REG_SOURCE, 32'h0000_1000, MOMENT_VBLANK);
      put(MODE_WR_DST, 2'd1, REG_SOURCE, 32'h8000_0000, MOMENT_VBLANK);
      put(MODE_WR_CTL, 2'd1, REG_CONTROL,
          ctl_value(1'b1, 1'b1, 1'b0, 1'b1, TIMING_VBL, AMODE_FIXED, AMODE_RELOAD, 21'd2),
          MOMENT_VBLANK);
      put(MODE_EVENT, 2'd0, REG_SOURCE, 32'h0, MOMENT_HBLANK);
      put_known(MODE_STEP, 2'd1, REG_SOURCE, 32'h0, MOMENT_VBLANK, 32'h0, 32'h1);
      put(MODE_EVENT, 2'd0, REG_SOURCE, 32'h0, MOMENT_VBLANK);
      put(MODE_STEP, 2'd1, REG_SOURCE, 32'h0, MOMENT_VBLANK);
      put(MODE_STEP, 2'd1, REG_SOURCE, 32'h0, MOMENT_VBLANK);
      // repeat transfer reloads the destination
      put(MODE_EVENT, 2'd2, REG_CONTROL, 32'hffff_ffff, MOMENT_VBLANK);
      put(MODE_STEP, 2'd1, REG_SOURCE, 32'h0, MOMENT_VBLANK);
      put(MODE_STEP, 2'd1, REG_SOURCE, 32'h0, MOMENT_VBLANK);
      put(MODE_WR_CTL, 2'd2, REG_CONTROL,
          ctl_value(1'b1, 1'b0, 1'b1, 1'b0, TIMING_HBL, AMODE_DECREMENT, AMODE_INCREMENT,
                    21'd1), MOMENT_VBLANK);
      put(MODE_EVENT, 2'd0, REG_SOURCE, 32'h0, MOMENT_HBLANK);
      put(MODE_STEP, 2'd2, REG_SOURCE, 32'h0, MOMENT_VBLANK);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      set_side(1'b1);
      foreach (script[i]) send_request(script[i].cmd, script[i].fixed, script[i].want);

      send_idle_pct = 0;
      stall_pct = 0;
      set_side(1'b1);
      run_traffic(165);
      set_side(1'b0);
      send_idle_pct = 60;
      stall_pct = 0;
      run_traffic(165);
      set_side(1'b1);
      send_idle_pct = 0;
      stall_pct = 60;
      run_traffic(160);
      set_side(1'b0);
      send_idle_pct = 6;
      stall_pct = 6;
      run_traffic(160);

      req_valid <= 1'b0;
      while (outcome_fifo.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0 && outcome_fifo.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
